// File: rtl/fpa_pkg.sv
// fpa_pkg: shared types, action codes and constants for the fixed-point alu
// no dependencies
`default_nettype none
package fpa_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned FracBitsDflt = 8;

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_MIN      = 4'd4,
    ACT_MAX      = 4'd5,
    ACT_INC      = 4'd6,
    ACT_DEC      = 4'd7,
    ACT_FROM_INT = 4'd8,
    ACT_TO_INT   = 4'd9
  } action_t;

  typedef struct packed {
    logic [3:0]        action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic              a_less;
    logic              a_equal;
    logic              a_greater;
    logic              overflow;
    logic              div_by_zero;
  } out_item_t;

  // control word carried along the divider cell row
  typedef struct packed {
    logic       vld;
    logic       is_div;
    logic       neg;
    logic       dz;
  } div_ctl_t;

endpackage
`default_nettype wire

// File: rtl/fpa_div_cell.sv
// fpa_div_cell: one restoring-division step of the divider row, registered
// depends on fpa_pkg
`default_nettype none
module fpa_div_cell #(
  parameter int unsigned NumW = 49,
  parameter int unsigned DenW = 33
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [NumW-1:0]   num_i,
  input  wire logic [DenW-1:0]   den_i,
  input  wire logic [NumW-1:0]   quo_i,
  input  wire logic [DenW-1:0]   rem_i,
  input  wire fpa_pkg::div_ctl_t ctl_i,
  input  wire logic [31:0]       alt_i,
  input  wire logic              aovf_i,
  input  wire logic [2:0]        cmp_i,
  output logic [NumW-1:0]        num_o,
  output logic [DenW-1:0]        den_o,
  output logic [NumW-1:0]        quo_o,
  output logic [DenW-1:0]        rem_o,
  output fpa_pkg::div_ctl_t      ctl_o,
  output logic [31:0]            alt_o,
  output logic                   aovf_o,
  output logic [2:0]             cmp_o
);
  // remainder shifts in the next numerator bit, subtracts the divisor if it fits
  logic [DenW:0]      rem_sh;
  logic [DenW:0]      diff;
  logic               fits;
  logic [DenW-1:0]    rem_nxt;

  assign rem_sh  = {rem_i, num_i[NumW-1]};
  assign diff    = rem_sh - {1'b0, den_i};
  assign fits    = !diff[DenW];
  assign rem_nxt = fits ? diff[DenW-1:0] : rem_sh[DenW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o  <= {num_i[NumW-2:0], 1'b0};
      den_o  <= den_i;
      quo_o  <= {quo_i[NumW-2:0], fits};
      rem_o  <= rem_nxt;
      alt_o  <= alt_i;
      aovf_o <= aovf_i;
      cmp_o  <= cmp_i;
    end
  end
endmodule
`default_nettype wire

// File: rtl/fixed_point_alu_core.sv
// fixed_point_alu_core: signed fixed-point alu, top level
// depends on fpa_pkg and fpa_div_cell
//
// channel | ports                     | payload
// input   | in_valid / in_ready       | fpa_pkg::in_item_t  (action, operand_a, operand_b)
// result  | out_valid / out_ready     | fpa_pkg::out_item_t (result, flags)
//
// one item per cycle while the output is not stalled, FRAC_BITS+36 register stages (decode,
// one cell per quotient bit, output register)
// every action rides the same row of division cells so results keep their order
// the whole row advances only when the output register is free or being drained
// reset (synchronous, active low) clears the valid bits of every stage
`default_nettype none
module fixed_point_alu_core #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDflt
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fpa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fpa_pkg::out_item_t      out_data
);
  localparam int unsigned NumW  = 32 + FRAC_BITS + 1 + 1; // |a|<<(F+1)
  localparam int unsigned DenW  = 33;                     // 2|b|
  localparam int unsigned Steps = NumW;
  localparam logic signed [65:0] Max32 = 66'sd2147483647;
  localparam logic signed [65:0] Min32 = -66'sd2147483648;

  logic adv;

  // stage 0: register the item, the product sign and the full product of the magnitudes
  fpa_pkg::in_item_t  s0_r;
  logic               s0_vld_r;
  logic signed [65:0] prod_r;
  logic               mul_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  logic [31:0] mag_a_in, mag_b_in;
  assign mag_a_in = in_data.operand_a[31] ? 32'(-in_data.operand_a) : in_data.operand_a;
  assign mag_b_in = in_data.operand_b[31] ? 32'(-in_data.operand_b) : in_data.operand_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r      <= in_data;
      prod_r    <= 66'(mag_a_in) * 66'(mag_b_in); // 32x32 unsigned multiply
      mul_neg_r <= in_data.operand_a[31] ^ in_data.operand_b[31];
    end
  end

  // stage 1: finish the simple actions, prepare division operands
  logic signed [65:0] a_x, b_x, wide, mrnd;
  logic [31:0]        alt;
  logic               aovf;
  logic [2:0]         cmp;
  logic [31:0]        ma, mb;

  assign a_x = 66'(s0_r.operand_a);
  assign b_x = 66'(s0_r.operand_b);
  assign ma  = s0_r.operand_a[31] ? 32'(-s0_r.operand_a) : s0_r.operand_a;
  assign mb  = s0_r.operand_b[31] ? 32'(-s0_r.operand_b) : s0_r.operand_b;
  assign mrnd = 66'(($unsigned(prod_r) + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  assign cmp = {s0_r.operand_a < s0_r.operand_b, s0_r.operand_a == s0_r.operand_b,
                s0_r.operand_a > s0_r.operand_b};

  always_comb begin
    wide = '0;
    unique case (s0_r.action)
      fpa_pkg::ACT_ADD:      wide = a_x + b_x;
      fpa_pkg::ACT_SUB:      wide = a_x - b_x;
      fpa_pkg::ACT_MUL:      wide = mul_neg_r ? -mrnd : mrnd;
      fpa_pkg::ACT_MIN:      wide = (a_x > b_x) ? b_x : a_x;
      fpa_pkg::ACT_MAX:      wide = (a_x > b_x) ? a_x : b_x;
      fpa_pkg::ACT_INC:      wide = a_x + 66'sd1;
      fpa_pkg::ACT_DEC:      wide = a_x - 66'sd1;
      fpa_pkg::ACT_FROM_INT: wide = a_x <<< FRAC_BITS;
      fpa_pkg::ACT_TO_INT:   wide = a_x >>> FRAC_BITS;
      default:               wide = '0;
    endcase
    aovf = 1'b0;
    if (wide > Max32) begin
      alt = 32'h7fff_ffff; aovf = 1'b1;
    end else if (wide < Min32) begin
      alt = 32'h8000_0000; aovf = 1'b1;
    end else begin
      alt = wide[31:0];
    end
  end

  fpa_pkg::div_ctl_t ctl0;
  assign ctl0 = '{vld:    s0_vld_r,
                  is_div: s0_r.action == fpa_pkg::ACT_DIV,
                  neg:    s0_r.operand_a[31] ^ s0_r.operand_b[31],
                  dz:     s0_r.operand_b == '0};

  // divider row: numerator (|a|<<(F+1)) + |b|, divisor 2|b|
  logic [NumW-1:0]       num_c [Steps+1];
  logic [DenW-1:0]       den_c [Steps+1];
  logic [NumW-1:0]       quo_c [Steps+1];
  logic [DenW-1:0]       rem_c [Steps+1];
  fpa_pkg::div_ctl_t     ctl_c [Steps+1];
  logic [31:0]           alt_c [Steps+1];
  logic                  aov_c [Steps+1];
  logic [2:0]            cmp_c [Steps+1];

  assign num_c[0] = (NumW'(ma) << (FRAC_BITS + 1)) + NumW'(mb);
  assign den_c[0] = {mb, 1'b0};
  assign quo_c[0] = '0;
  assign rem_c[0] = '0;
  assign ctl_c[0] = ctl0;
  assign alt_c[0] = alt;
  assign aov_c[0] = aovf;
  assign cmp_c[0] = cmp;

  for (genvar i = 0; i < Steps; i++) begin : g_row
    fpa_div_cell #(.NumW(NumW), .DenW(DenW)) u_cell (
      .clk, .rst_n, .en(adv),
      .num_i(num_c[i]), .den_i(den_c[i]), .quo_i(quo_c[i]), .rem_i(rem_c[i]),
      .ctl_i(ctl_c[i]), .alt_i(alt_c[i]), .aovf_i(aov_c[i]), .cmp_i(cmp_c[i]),
      .num_o(num_c[i+1]), .den_o(den_c[i+1]), .quo_o(quo_c[i+1]), .rem_o(rem_c[i+1]),
      .ctl_o(ctl_c[i+1]), .alt_o(alt_c[i+1]), .aovf_o(aov_c[i+1]), .cmp_o(cmp_c[i+1])
    );
  end

  // final: sign and saturate the quotient, pick result
  fpa_pkg::div_ctl_t  fc;
  logic [NumW-1:0]    q;
  logic               qbig;
  fpa_pkg::out_item_t res;

  assign fc   = ctl_c[Steps];
  assign q    = quo_c[Steps];
  // negative quotients reach down to -2^31, positive ones up to 2^31-1
  assign qbig = fc.neg ? (q > NumW'(32'h8000_0000)) : (q > NumW'(32'h7fff_ffff));

  always_comb begin
    res             = '0;
    res.a_less      = cmp_c[Steps][2];
    res.a_equal     = cmp_c[Steps][1];
    res.a_greater   = cmp_c[Steps][0];
    if (!fc.is_div) begin
      res.result   = alt_c[Steps];
      res.overflow = aov_c[Steps];
    end else if (fc.dz) begin
      res.div_by_zero = 1'b1;
    end else if (qbig) begin
      res.overflow = 1'b1;
      res.result   = fc.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      res.result = fc.neg ? 32'(-q[31:0]) : q[31:0];
    end
  end

  // output register, the row stalls when it holds an untaken transfer
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fc.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

  // exactly one compare flag on every result
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.a_less, out_data.a_equal, out_data.a_greater}))
    else $error("compare flags not one-hot");
  // divide by zero never reports overflow and forces zero
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_by_zero |-> !out_data.overflow && out_data.result == '0)
    else $error("divide by zero result wrong");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
endmodule
`default_nettype wire

// File: bench/fpa_checker.sv
// fpa_checker: watches both channels of the fixed-point alu, predicts each result, compares
// depends on fpa_pkg
`timescale 1ns / 1ps
module fpa_checker #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDflt
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  fpa_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  fpa_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_count
);
  fpa_pkg::out_item_t expected_results[$];

  function automatic logic signed [31:0] saturate(input logic signed [65:0] v,
                                                  inout logic ovf);
    if (v > 66'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -66'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic fpa_pkg::out_item_t alu_predict(input fpa_pkg::in_item_t it);
    fpa_pkg::out_item_t o;
    logic signed [65:0] a, b, r;
    logic [65:0] ma, mb, m;
    logic neg;
    o = '0;
    a = it.operand_a;
    b = it.operand_b;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    r = 0;
    case (it.action)
      fpa_pkg::ACT_ADD: o.result = saturate(a + b, o.overflow);
      fpa_pkg::ACT_SUB: o.result = saturate(a - b, o.overflow);
      fpa_pkg::ACT_MUL: begin
        m = (ma * mb + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r = neg ? -$signed(m) : $signed(m);
        o.result = saturate(r, o.overflow);
      end
      fpa_pkg::ACT_DIV: begin
        if (b == 0) begin
          o.div_by_zero = 1'b1;
        end else begin
          m = ((ma << (FRAC_BITS + 1)) + mb) / (mb << 1);
          r = neg ? -$signed(m) : $signed(m);
          o.result = saturate(r, o.overflow);
        end
      end
      fpa_pkg::ACT_MIN: o.result = (a > b) ? it.operand_b : it.operand_a;
      fpa_pkg::ACT_MAX: o.result = (a > b) ? it.operand_a : it.operand_b;
      fpa_pkg::ACT_INC: o.result = saturate(a + 1, o.overflow);
      fpa_pkg::ACT_DEC: o.result = saturate(a - 1, o.overflow);
      fpa_pkg::ACT_FROM_INT: o.result = saturate(a <<< FRAC_BITS, o.overflow);
      fpa_pkg::ACT_TO_INT: o.result = it.operand_a >>> FRAC_BITS;
      default: o.result = '0;
    endcase
    o.a_less = a < b;
    o.a_equal = a == b;
    o.a_greater = a > b;
    return o;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    fpa_pkg::out_item_t exp_item;
    if (rst_n && in_valid && in_ready) expected_results.push_back(alu_predict(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected transfer %h", out_data);
      end else begin
        exp_item = expected_results.pop_front();
        if (exp_item !== out_data) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp res %h lt%b eq%b gt%b ov%b dz%b, got res %h lt%b eq%b gt%b ov%b dz%b",
                     exp_item.result, exp_item.a_less, exp_item.a_equal, exp_item.a_greater,
                     exp_item.overflow, exp_item.div_by_zero, out_data.result, out_data.a_less,
                     out_data.a_equal, out_data.a_greater, out_data.overflow,
                     out_data.div_by_zero);
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule

// File: bench/tb.sv
// tb: stimulus and verdict for fixed_point_alu_core
// depends on fpa_pkg, fixed_point_alu_core and fpa_checker
`timescale 1ns / 1ps
module tb;
  localparam int unsigned FB = fpa_pkg::FracBitsDflt;
  localparam int Latency = FB + 36;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  fpa_pkg::in_item_t in_data;
  fpa_pkg::out_item_t out_data;
  int fail_count, pending_count;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;

  fixed_point_alu_core #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  fpa_checker #(.FRAC_BITS(FB)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // random operand biased toward the edges of the range and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 2) - 1;
      3: return $signed($urandom_range(0, 8191)) - 4096;
      4: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // one transfer on the input channel, with random idle cycles first
  task automatic send_op(input logic [3:0] act, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{action: act, operand_a: a, operand_b: b};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls unless a long hold-off is under way
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // long hold-off so the pipeline fills and in_ready drops
  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (300) @(negedge clk);
    hold_off = 1'b1;
    repeat (Latency * 3) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    logic [31:0] edge_vals[6];
    int waited;
    edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h100};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 34;
    recv_idle_pct = 59;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: every action on edge operands, ties, division by zero, unused codes
    for (int k = 0; k < 10; k++) send_op(k[3:0], edge_vals[k % 6], edge_vals[(k + 1) % 6]);
    send_op(fpa_pkg::ACT_DIV, 32'h100, 32'h0);
    send_op(fpa_pkg::ACT_MUL, 32'h1, 32'h80);
    send_op(fpa_pkg::ACT_MUL, 32'hffffffff, 32'h80);
    send_op(fpa_pkg::ACT_DIV, 32'h1, 32'h200);
    send_op(fpa_pkg::ACT_DIV, 32'h80000000, 32'hffffffff);
    send_op(fpa_pkg::ACT_MIN, 32'h5, 32'h5);
    send_op(fpa_pkg::ACT_MAX, 32'h80000000, 32'h80000000);
    send_op(fpa_pkg::ACT_INC, 32'h7fffffff, 32'h0);
    send_op(fpa_pkg::ACT_DEC, 32'h80000000, 32'h0);
    send_op(fpa_pkg::ACT_FROM_INT, 32'h00800000, 32'h0);
    send_op(fpa_pkg::ACT_TO_INT, 32'hfffffe80, 32'h0);
    send_op(4'd10, 32'h3, 32'h2);
    send_op(4'd15, 32'hffffffff, 32'hffffffff);

    for (int i = 0; i < 1050; i++) begin
      if (i == 350) begin
        send_idle_pct = 59;
        recv_idle_pct = 34;
      end else if (i == 700) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_op(4'(($urandom_range(0, 19) == 0) ? $urandom_range(10, 15)
                                                : $urandom_range(0, 9)),
              pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_count != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (Latency + 10) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
